[hdl/slipfr_pkg.sv]
// ----------------------------------------------------------------------------
// slipfr_pkg
// Shared types and constants of the SLIP frame receiver: line codes, widths,
// controller state encoding and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package slipfr_pkg;

  localparam int unsigned DefFrameDepth = 64;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned CountW        = 7;

  localparam logic [ByteW-1:0] SlipEnd    = 8'hC0;
  localparam logic [ByteW-1:0] SlipEsc    = 8'hDB;
  localparam logic [ByteW-1:0] SlipEscEnd = 8'hDC;
  localparam logic [ByteW-1:0] SlipEscEsc = 8'hDD;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StShow
  } slipfr_state_e;

  // Controller to datapath
  typedef struct packed {
    logic take;     // raw byte accepted on the input channel
    logic rd_en;    // read the frame store at the replay pointer
    logic rd_next;  // advance the replay pointer
    logic clear;    // frame delivered: clear count, flag and pointer
  } slipfr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic end_frame;  // input byte is END and the store holds bytes
    logic rd_last;    // replay pointer is on the last stored byte
  } slipfr_sts_t;

endpackage : slipfr_pkg

`default_nettype wire

[hdl/slipfr_dpath.sv]
// ----------------------------------------------------------------------------
// slipfr_dpath
// Datapath: SLIP unescaping, escape flag, frame store with byte count, and
// the replay pointer with its registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module slipfr_dpath
  import slipfr_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = DefFrameDepth
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire  [ByteW-1:0]   rx_byte_i,
  input  slipfr_cmd_t        cmd_i,
  output slipfr_sts_t        sts_o,
  output logic [ByteW-1:0]   frame_byte_o,
  output logic               frame_last_o,
  output logic [CountW-1:0]  frame_length_o
);

  localparam int unsigned IdxW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam logic [CountW-1:0] DepthC = CountW'(FRAME_DEPTH);

  logic [ByteW-1:0]  mem_q [FRAME_DEPTH];
  logic [ByteW-1:0]  rd_data_q;
  logic [CountW-1:0] count_q, count_d;
  logic              esc_q, esc_d;
  logic [IdxW-1:0]   rd_idx_q, rd_idx_d;

  logic              is_end;
  logic [ByteW-1:0]  decoded;
  logic              store;
  logic              wr_en;

  assign is_end = (rx_byte_i == SlipEnd);

  always_comb begin
    decoded = rx_byte_i;
    store   = 1'b0;
    esc_d   = esc_q;
    if (cmd_i.take && !is_end) begin
      if (esc_q) begin
        esc_d = 1'b0;
        store = 1'b1;
        if (rx_byte_i == SlipEscEnd) begin
          decoded = SlipEnd;
        end else if (rx_byte_i == SlipEscEsc) begin
          decoded = SlipEsc;
        end
      end else if (rx_byte_i == SlipEsc) begin
        esc_d = 1'b1;
      end else begin
        store = 1'b1;
      end
    end
    if (cmd_i.clear) begin
      esc_d = 1'b0;
    end
  end

  // Drop bytes once the store is full
  assign wr_en = store && (count_q < DepthC);

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (wr_en) begin
      count_d = count_q + CountW'(1);
    end
  end

  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.clear) begin
      rd_idx_d = '0;
    end else if (cmd_i.rd_next) begin
      rd_idx_d = rd_idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      esc_q    <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      count_q  <= count_d;
      esc_q    <= esc_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[IdxW-1:0]] <= decoded;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_idx_q];
    end
  end

  assign sts_o.end_frame = is_end && (count_q != '0);
  assign sts_o.rd_last   = (count_q == (CountW'(rd_idx_q) + CountW'(1)));

  assign frame_byte_o   = rd_data_q;
  assign frame_last_o   = sts_o.rd_last;
  assign frame_length_o = count_q;

endmodule : slipfr_dpath

`default_nettype wire

[hdl/slipfr_ctrl.sv]
// ----------------------------------------------------------------------------
// slipfr_ctrl
// Controller: takes raw bytes while idle and sequences the frame replay,
// one store read and one output transaction per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module slipfr_ctrl
  import slipfr_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          rx_valid_i,
  output logic         rx_ready_o,
  output logic         frame_valid_o,
  input  wire          frame_ready_i,
  input  slipfr_sts_t  sts_i,
  output slipfr_cmd_t  cmd_o
);

  slipfr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    rx_ready_o    = 1'b0;
    frame_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        rx_ready_o = 1'b1;
        if (rx_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.end_frame) begin
            state_d = StRead;
          end
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StShow;
      end
      StShow: begin
        frame_valid_o = 1'b1;
        if (frame_ready_i) begin
          if (sts_i.rd_last) begin
            cmd_o.clear = 1'b1;
            state_d     = StIdle;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = StRead;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule : slipfr_ctrl

`default_nettype wire

[hdl/slip_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// slip_frame_receiver_top
// SLIP frame decoder: unescapes received line bytes into a frame store and
// replays a completed frame byte by byte when END arrives.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                      Payload
//   rx       in         rx_valid_i / rx_ready_o        rx_byte_i
//   frame    out        frame_valid_o / frame_ready_i  frame_byte_o, frame_last_o,
//                                                      frame_length_o
//
// A data, ESC, or empty-frame END byte is taken while idle. An END that closes
// a frame holds rx_ready_o low until its last byte is delivered, output stalls
// included: each byte is read on the store's registered read port (StRead) and
// then presented as a transaction (StShow).
// Reset clears the state machine, byte count, escape flag and replay pointer;
// the frame store itself is not cleared (only written entries are replayed).
// Stalls on frame_ready_i hold the presented byte; no input is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module slip_frame_receiver_top
  import slipfr_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = DefFrameDepth
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  // received line bytes
  input  wire                rx_valid_i,
  output logic               rx_ready_o,
  input  wire  [ByteW-1:0]   rx_byte_i,
  // decoded frame bytes
  output logic               frame_valid_o,
  input  wire                frame_ready_i,
  output logic [ByteW-1:0]   frame_byte_o,
  output logic               frame_last_o,
  output logic [CountW-1:0]  frame_length_o
);

  slipfr_cmd_t cmd;
  slipfr_sts_t sts;

  // Sequence input transactions and frame replay
  slipfr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (rx_valid_i),
    .rx_ready_o    (rx_ready_o),
    .frame_valid_o (frame_valid_o),
    .frame_ready_i (frame_ready_i),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // Unescape, store and read back frame bytes
  slipfr_dpath #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .frame_byte_o   (frame_byte_o),
    .frame_last_o   (frame_last_o),
    .frame_length_o (frame_length_o)
  );

endmodule : slip_frame_receiver_top

`default_nettype wire

[bench/slip_frame_receiver_checker.sv]
// ----------------------------------------------------------------------------
// slip_frame_receiver_checker
// Watches both channels of the SLIP frame receiver. It decodes every accepted
// line byte on its own, queues the frame bytes that an END must replay, and
// compares each frame transaction field by field with the oldest queued one.
// ----------------------------------------------------------------------------
`default_nettype none

module slip_frame_receiver_checker
  import slipfr_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = DefFrameDepth
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                rx_valid_i,
  input  wire                rx_ready_i,
  input  wire  [ByteW-1:0]   rx_byte_i,
  input  wire                frame_valid_i,
  input  wire                frame_ready_i,
  input  wire  [ByteW-1:0]   frame_byte_i,
  input  wire                frame_last_i,
  input  wire  [CountW-1:0]  frame_length_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  typedef struct packed {
    logic [ByteW-1:0]  data;
    logic              last;
    logic [CountW-1:0] length;
  } frame_beat_t;

  frame_beat_t      replay_queue[$];
  logic [ByteW-1:0] decoded_frame [FRAME_DEPTH];
  int unsigned      decoded_count;
  logic             escape_armed;
  int unsigned      mismatches;

  task automatic decode_line_byte(input logic [ByteW-1:0] line_byte);
    logic [ByteW-1:0] value;
    frame_beat_t      beat;
    value = line_byte;
    if (line_byte == SlipEnd) begin
      // END replays the stored frame; an empty store leaves the flag alone
      for (int unsigned k = 0; k < decoded_count; k++) begin
        beat.data   = decoded_frame[k];
        beat.last   = (k + 1 == decoded_count);
        beat.length = CountW'(decoded_count);
        replay_queue.push_back(beat);
      end
      if (decoded_count != 0) escape_armed = 1'b0;
      decoded_count = 0;
    end else if (escape_armed || line_byte != SlipEsc) begin
      if (escape_armed) begin
        if (line_byte == SlipEscEnd) value = SlipEnd;
        else if (line_byte == SlipEscEsc) value = SlipEsc;
      end
      escape_armed = 1'b0;
      // drop bytes once the store is full
      if (decoded_count < FRAME_DEPTH) begin
        decoded_frame[decoded_count] = value;
        decoded_count++;
      end
    end else begin
      escape_armed = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_beat_t want;
    if (!rst_ni) begin
      replay_queue.delete();
      decoded_count = 0;
      escape_armed  = 1'b0;
      mismatches    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (frame_valid_i && frame_ready_i) begin
        if (replay_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected frame transaction: byte %h last %b length %0d",
                     frame_byte_i, frame_last_i, frame_length_i);
        end else begin
          want = replay_queue.pop_front();
          if (frame_byte_i !== want.data || frame_last_i !== want.last ||
              frame_length_i !== want.length) begin
            mismatches++;
            if (mismatches <= 10)
              $display("frame mismatch: expected byte %h last %b length %0d, got %h %b %0d",
                       want.data, want.last, want.length,
                       frame_byte_i, frame_last_i, frame_length_i);
          end
        end
      end
      if (rx_valid_i && rx_ready_i) decode_line_byte(rx_byte_i);
      fail_count_o <= mismatches;
      pending_o    <= replay_queue.size();
    end
  end

endmodule : slip_frame_receiver_checker

`default_nettype wire

[bench/slip_frame_receiver_top_tb.sv]
// ----------------------------------------------------------------------------
// slip_frame_receiver_top_tb
// Feeds SLIP line bytes into the frame receiver: a directed opening that hits
// empty frames, escapes, an escaped END and the extreme byte values, then
// random frames with random content, noise and overflowing lengths. Both
// sides idle at random, and the frame side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module slip_frame_receiver_top_tb;
  import slipfr_pkg::*;

  localparam int unsigned RandomItems   = 460;
  localparam int unsigned MaxIdle       = 18;
  localparam int unsigned HoldOffCycles = 600;
  localparam int unsigned HoldOffAfter  = 60;
  localparam int unsigned CycleLimit    = 300000;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              rx_valid      = 1'b0;
  logic [ByteW-1:0]  rx_byte       = '0;
  logic              frame_ready   = 1'b0;
  logic              rx_ready;
  logic              frame_valid;
  logic [ByteW-1:0]  frame_byte;
  logic              frame_last;
  logic [CountW-1:0] frame_length;

  int unsigned fail_count;
  int unsigned pending;

  // stimulus bookkeeping
  int unsigned lines_sent   = 0;
  logic        line_burst   = 1'b0;
  // frame side bookkeeping
  logic        hold_off     = 1'b0;
  logic        drain_burst  = 1'b0;
  int unsigned stall_left   = 0;
  int unsigned beats_taken  = 0;
  int unsigned cycle_count  = 0;

  slip_frame_receiver_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .rx_valid_i     (rx_valid),
    .rx_ready_o     (rx_ready),
    .rx_byte_i      (rx_byte),
    .frame_valid_o  (frame_valid),
    .frame_ready_i  (frame_ready),
    .frame_byte_o   (frame_byte),
    .frame_last_o   (frame_last),
    .frame_length_o (frame_length)
  );

  slip_frame_receiver_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .rx_valid_i     (rx_valid),
    .rx_ready_i     (rx_ready),
    .rx_byte_i      (rx_byte),
    .frame_valid_i  (frame_valid),
    .frame_ready_i  (frame_ready),
    .frame_byte_i   (frame_byte),
    .frame_last_i   (frame_last),
    .frame_length_i (frame_length),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one line byte and return at the edge where the transaction happens.
  // Lower valid only when a gap follows, so valid never drops and rises in
  // the same step. Ready is looked at on the falling edge, where it is settled.
  task automatic send_line_byte(input logic [ByteW-1:0] line_byte);
    int unsigned gap;
    gap = line_burst ? 0 : $urandom_range(MaxIdle, 0);
    if (gap != 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= line_byte;
    @(negedge clk);
    while (!rx_ready) @(negedge clk);
    @(posedge clk);
    lines_sent++;
  endtask

  // Encode one payload byte the way a well-behaved sender would.
  task automatic send_payload_byte(input logic [ByteW-1:0] value);
    if (value == SlipEnd) begin
      send_line_byte(SlipEsc);
      send_line_byte(SlipEscEnd);
    end else if (value == SlipEsc) begin
      send_line_byte(SlipEsc);
      send_line_byte(SlipEscEsc);
    end else begin
      send_line_byte(value);
    end
  endtask

  // Send one random frame: mostly clean content, with some raw escape codes,
  // stray ESC pairs and now and then a dangling ESC before the closing END.
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned length;
    pick = $urandom_range(19, 0);
    if (pick == 0) length = $urandom_range(70, 60);
    else if (pick == 1) length = 0;
    else length = $urandom_range(12, 1);
    for (int unsigned i = 0; i < length; i++) begin
      case ($urandom_range(9, 0))
        0: begin
          send_payload_byte($urandom_range(1, 0) ? SlipEnd : SlipEsc);
        end
        1: begin
          // stray ESC ahead of any byte, END included
          send_line_byte(SlipEsc);
          send_line_byte(ByteW'($urandom_range(255, 0)));
        end
        2: begin
          send_line_byte($urandom_range(1, 0) ? SlipEscEnd : SlipEscEsc);
        end
        default: begin
          send_payload_byte(ByteW'($urandom_range(255, 0)));
        end
      endcase
    end
    if ($urandom_range(9, 0) == 0) send_line_byte(SlipEsc);
    send_line_byte(SlipEnd);
  endtask

  initial begin
    // Hold reset, then release it for good.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // END on an empty store: no transaction.
    send_line_byte(SlipEnd);
    // Extreme data values in a plain frame.
    send_line_byte(8'h00);
    send_line_byte(8'hFF);
    send_line_byte(8'h01);
    send_line_byte(8'h80);
    send_line_byte(SlipEnd);
    // Every escape form: ESC_END, ESC_ESC, other byte, escaped ESC, and a raw
    // ESC_END afterwards that must not be unescaped.
    send_line_byte(SlipEsc);
    send_line_byte(SlipEscEnd);
    send_line_byte(SlipEsc);
    send_line_byte(SlipEscEsc);
    send_line_byte(SlipEsc);
    send_line_byte(8'h41);
    send_line_byte(SlipEsc);
    send_line_byte(SlipEsc);
    send_line_byte(SlipEscEnd);
    send_line_byte(SlipEnd);
    // Escaped END still closes a non-empty frame and clears the flag.
    send_line_byte(8'h55);
    send_line_byte(SlipEsc);
    send_line_byte(SlipEnd);
    // Escaped END on an empty store keeps the flag armed for the next byte.
    send_line_byte(SlipEsc);
    send_line_byte(SlipEnd);
    send_line_byte(SlipEscEnd);
    send_line_byte(SlipEnd);

    // Random frames; every fourth frame or so goes without line gaps.
    while (lines_sent < 23 + RandomItems) begin
      line_burst = ($urandom_range(3, 0) == 0);
      send_random_frame();
    end
    rx_valid <= 1'b0;

    // Drain the outstanding frame bytes, then let the block settle.
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Long hold-off on the frame side while line bytes keep coming, so that a
  // replay stalls and the input channel backs up behind it.
  initial begin
    @(negedge clk);
    while (lines_sent < HoldOffAfter) @(negedge clk);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Frame side: after each transaction draw a stall, except in stall-free
  // stretches; the mode flips every forty transactions.
  always @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      beats_taken++;
      if (beats_taken % 40 == 0) drain_burst = !drain_burst;
      stall_left = drain_burst ? 0 : $urandom_range(MaxIdle, 0);
    end
    if (hold_off) begin
      frame_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      frame_ready <= 1'b0;
    end else begin
      frame_ready <= 1'b1;
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule : slip_frame_receiver_top_tb

`default_nettype wire
